// ===== hdl/bac_pkg.sv =====
`default_nettype none
package bac_pkg;

  // Fixed sizes of the time word and its digits.
  localparam int TIME_DIGITS = 6;
  localparam int TIME_W      = 22;
  localparam int DIGIT_W     = 4;
  localparam int TICK_W      = 16;
  localparam int SNOOZE_W    = 8;

  // Snooze interval in minute rollovers.
  localparam logic [SNOOZE_W-1:0] SNOOZE_MINUTES = 8'd5;
  localparam logic [SNOOZE_W-1:0] SNOOZE_LAST    = SNOOZE_MINUTES - 8'd1;

  // Wrap limits of the digit positions.
  localparam logic [DIGIT_W:0] UNIT_LIMIT      = 5'd10;
  localparam logic [DIGIT_W:0] TENS_LIMIT      = 5'd6;
  localparam logic [DIGIT_W:0] HOUR_TENS_LIMIT = 5'd4;

  // Hour values that end the day.
  localparam logic [1:0]         HOUR_TENS_OVER = 2'd3;
  localparam logic [1:0]         HOUR_TENS_LAST = 2'd2;
  localparam logic [DIGIT_W-1:0] HOUR_UNITS_END = 4'd4;

  // Reset value of the prescaler limit.
  localparam logic [TICK_W-1:0] TPS_RESET = 16'd1000;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_SNOOZE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_TICKS_PER_SECOND = 2'd0,
    CFG_ALARM_TIME       = 2'd1,
    CFG_ALARM_ENABLED    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] new_time;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_bcd;
    logic              time_valid;
    logic              alarm_fire;
    logic              snooze_fire;
    logic              second_indicator;
  } result_t;

  // Control handed to one digit cell in a cycle.
  typedef struct packed {
    logic               carry_in;
    logic               load;
    logic [DIGIT_W-1:0] load_digit;
    logic               clear;
    logic [DIGIT_W:0]   limit;
  } cell_ctl_t;

  // Status handed back by one digit cell.
  typedef struct packed {
    logic               carry_out;
    logic [DIGIT_W-1:0] digit_pre;
    logic [DIGIT_W-1:0] digit_next;
  } cell_sts_t;

  // Wrap limit of digit position k, counted from the second units.
  function automatic logic [DIGIT_W:0] digit_limit(input int k);
    logic [DIGIT_W:0] lim;
    case (k)
      1, 3:    lim = TENS_LIMIT;
      5:       lim = HOUR_TENS_LIMIT;
      default: lim = UNIT_LIMIT;
    endcase
    return lim;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bac_digit_cell.sv =====
`default_nettype none
module bac_digit_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bac_pkg::cell_ctl_t ctl,
  output bac_pkg::cell_sts_t      sts
);

  logic [bac_pkg::DIGIT_W-1:0] digit;
  logic [bac_pkg::DIGIT_W:0]   sum;
  logic                        wrap;

  // Increment on an incoming carry; wrap and pass the carry on at the limit.
  always_comb begin
    sum  = {1'b0, digit} + {{bac_pkg::DIGIT_W{1'b0}}, 1'b1};
    wrap = (sum >= ctl.limit);
    sts.carry_out = ctl.carry_in & wrap;
    if (ctl.carry_in) begin
      sts.digit_pre = wrap ? '0 : sum[bac_pkg::DIGIT_W-1:0];
    end else begin
      sts.digit_pre = digit;
    end
    if (ctl.load) begin
      sts.digit_next = ctl.load_digit;
    end else if (ctl.clear) begin
      sts.digit_next = '0;
    end else begin
      sts.digit_next = sts.digit_pre;
    end
  end

  // Digit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= '0;
    end else begin
      digit <= sts.digit_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bac_prescaler.sv =====
`default_nettype none
module bac_prescaler (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tick,
  input  wire logic [bac_pkg::TICK_W-1:0]  ticks_per_second,
  output logic                             rollover,
  output logic                             lamp_next
);

  logic [bac_pkg::TICK_W-1:0] tick_count;
  logic [bac_pkg::TICK_W-1:0] tick_count_next;
  logic [bac_pkg::TICK_W-1:0] count_inc;
  logic                       lamp;

  // Count ticks; the lamp lights at half a second and goes dark at the rollover.
  always_comb begin
    count_inc       = tick_count + {{(bac_pkg::TICK_W-1){1'b0}}, 1'b1};
    rollover        = 1'b0;
    tick_count_next = tick_count;
    lamp_next       = lamp;
    if (tick) begin
      tick_count_next = count_inc;
      if (count_inc == (ticks_per_second >> 1)) begin
        lamp_next = 1'b1;
      end
      if (count_inc >= ticks_per_second) begin
        rollover        = 1'b1;
        tick_count_next = '0;
        lamp_next       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      lamp       <= 1'b0;
    end else begin
      tick_count <= tick_count_next;
      lamp       <= lamp_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bcd_alarm_clock.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_ready   item   (kind, new_time)
// result    out        result_valid / result_ready result (time, flags)
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The six digit cells ripple the seconds carry and register the new time
// in the cycle the beat is accepted.
// One result beat per item appears the cycle after acceptance.
// item_ready stays high while the result register is empty or being drained,
// so a new beat is accepted in the same cycle a waiting result is taken.
// Synchronous reset clears the time, prescaler, snooze and lamp state and
// loads the register reset values; cfg_ready is always high.
module bcd_alarm_clock (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire bac_pkg::item_t              item,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output bac_pkg::result_t                 result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [bac_pkg::TIME_W-1:0]  cfg_data
);

  localparam int DW = bac_pkg::DIGIT_W;
  localparam int ND = bac_pkg::TIME_DIGITS;

  // Configuration registers.
  logic [bac_pkg::TICK_W-1:0] ticks_per_second;
  logic [bac_pkg::TIME_W-1:0] alarm_time;
  logic                       alarm_enabled;

  // Clock state outside the cells.
  logic                         time_loaded;
  logic                         time_loaded_next;
  logic                         snooze_pending;
  logic                         snooze_pending_next;
  logic [bac_pkg::SNOOZE_W-1:0] snooze_minutes;
  logic [bac_pkg::SNOOZE_W-1:0] snooze_minutes_next;

  logic accept;
  logic is_tick;
  logic is_load;
  logic rollover;
  logic lamp_next;
  logic hour_wrap;
  logic minute;
  logic alarm_fire;
  logic snooze_fire;

  logic [bac_pkg::TIME_W-1:0] load_word;
  logic [bac_pkg::TIME_W-1:0] time_next;
  logic [ND:0]                carry;

  bac_pkg::cell_ctl_t ctl [ND];
  bac_pkg::cell_sts_t sts [ND];

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign is_tick    = accept && (item.kind == bac_pkg::KIND_TICK);
  assign is_load    = accept && (item.kind == bac_pkg::KIND_LOAD);
  assign load_word  = item.new_time;

  bac_prescaler u_prescaler (
    .clk              (clk),
    .rst              (rst),
    .tick             (is_tick),
    .ticks_per_second (ticks_per_second),
    .rollover         (rollover),
    .lamp_next        (lamp_next)
  );

  // Row of digit cells, seconds units first; each hands its carry to the next.
  assign carry[0] = rollover;

  for (genvar k = 0; k < ND; k++) begin : g_cell
    if (k == ND - 1) begin : g_hour_tens
      // The hour tens digit holds only the top two bits of the word.
      always_comb begin
        ctl[k].carry_in   = carry[k];
        ctl[k].load       = is_load;
        ctl[k].limit      = bac_pkg::digit_limit(k);
        ctl[k].load_digit = {2'b00, load_word[bac_pkg::TIME_W-1 -: 2]};
        ctl[k].clear      = hour_wrap;
      end
    end else begin : g_low_digit
      always_comb begin
        ctl[k].carry_in   = carry[k];
        ctl[k].load       = is_load;
        ctl[k].limit      = bac_pkg::digit_limit(k);
        ctl[k].load_digit = load_word[DW*k +: DW];
        ctl[k].clear      = (k == ND - 2) ? hour_wrap : 1'b0;
      end
    end

    bac_digit_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl[k]),
      .sts (sts[k])
    );

    assign carry[k+1] = sts[k].carry_out;
  end

  // End of day: the hours return to zero after the minute tens carry.
  assign hour_wrap = carry[4] &&
                     (carry[ND] ||
                      (sts[5].digit_pre[1:0] == bac_pkg::HOUR_TENS_OVER) ||
                      ((sts[5].digit_pre[1:0] == bac_pkg::HOUR_TENS_LAST) &&
                       (sts[4].digit_pre >= bac_pkg::HOUR_UNITS_END)));

  assign minute = carry[2];

  // Assemble the time word after this item.
  always_comb begin
    time_next = '0;
    for (int k = 0; k < ND - 1; k++) begin
      time_next[DW*k +: DW] = sts[k].digit_next;
    end
    time_next[bac_pkg::TIME_W-1 -: 2] = sts[ND-1].digit_next[1:0];
  end

  // Alarm compare and snooze counting at the minute rollover.
  always_comb begin
    time_loaded_next    = time_loaded;
    snooze_pending_next = snooze_pending;
    snooze_minutes_next = snooze_minutes;
    alarm_fire          = 1'b0;
    snooze_fire         = 1'b0;
    if (accept) begin
      case (item.kind)
        bac_pkg::KIND_TICK: begin
          if (minute) begin
            alarm_fire = alarm_enabled && (time_next == alarm_time);
            if (snooze_pending) begin
              if (snooze_minutes == bac_pkg::SNOOZE_LAST) begin
                snooze_minutes_next = '0;
                snooze_pending_next = 1'b0;
                snooze_fire         = 1'b1;
              end else begin
                snooze_minutes_next = snooze_minutes + 8'd1;
              end
            end
          end
        end
        bac_pkg::KIND_LOAD: begin
          time_loaded_next    = 1'b1;
          snooze_pending_next = 1'b0;
        end
        bac_pkg::KIND_SNOOZE: begin
          snooze_pending_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cfg_valid && (cfg_index == bac_pkg::CFG_ALARM_TIME)) begin
      snooze_minutes_next = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= bac_pkg::TPS_RESET;
      alarm_time       <= '0;
      alarm_enabled    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bac_pkg::CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[bac_pkg::TICK_W-1:0];
        bac_pkg::CFG_ALARM_TIME:       alarm_time       <= cfg_data;
        bac_pkg::CFG_ALARM_ENABLED:    alarm_enabled    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Snooze and load state.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_loaded    <= 1'b0;
      snooze_pending <= 1'b0;
      snooze_minutes <= '0;
    end else begin
      time_loaded    <= time_loaded_next;
      snooze_pending <= snooze_pending_next;
      snooze_minutes <= snooze_minutes_next;
    end
  end

  // Output register: one result beat per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.time_bcd         <= time_next;
      result.time_valid       <= time_loaded_next;
      result.alarm_fire       <= alarm_fire;
      result.snooze_fire      <= snooze_fire;
      result.second_indicator <= lamp_next;
    end
  end

endmodule
`default_nettype wire
